// ===== hdl/mclw_pkg.sv =====
// ----------------------------------------------------------------------------
// mclw_pkg
// shared types, sizes and codes of the liveness watchdog bank
// ----------------------------------------------------------------------------
package mclw_pkg;

  localparam int MAX_CHANNELS   = 16;
  localparam int COUNT_BITS     = 16;
  localparam int DEFAULT_RELOAD = 100;

  // slot index and fill count widths
  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

  typedef enum logic [1:0] {
    MODE_REGISTER = 2'd0,
    MODE_TICK     = 2'd1,
    MODE_KICK     = 2'd2,
    MODE_QUERY    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_ACK     = 3'd0,
    KIND_OFFLINE = 3'd1,
    KIND_STATUS  = 3'd2,
    KIND_ERROR   = 3'd3,
    KIND_DONE    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG,
    ST_KICK,
    ST_QUERY,
    ST_TICK,
    ST_TICK_DONE
  } state_e;

  typedef struct packed {
    mode_e       mode;
    logic [3:0]  channel;
    logic [7:0]  owner_tag;
    logic [15:0] reload_value;
    logic [15:0] initial_value;
    logic        has_handler;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] slot;
    logic [7:0] owner;
    logic       online;
    logic       last;
  } out_item_t;

  // one record per channel, held in the channel memory
  typedef struct packed {
    logic [COUNT_BITS-1:0] reload;
    logic [COUNT_BITS-1:0] countdown;
    logic                  online;
    logic [7:0]            owner;
    logic                  handler;
  } chan_rec_t;

endpackage

// ===== hdl/mclw_ram.sv =====
// ----------------------------------------------------------------------------
// mclw_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mclw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mclw_ctrl.sv =====
// ----------------------------------------------------------------------------
// mclw_ctrl
// command sequencer: read, modify and write back channel records
// ----------------------------------------------------------------------------
module mclw_ctrl import mclw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  input  logic             out_free_i,
  output logic             push_o,
  output out_item_t        res_o,
  output logic             ram_we_o,
  output logic [IDX_W-1:0] ram_waddr_o,
  output chan_rec_t        ram_wdata_o,
  output logic             ram_re_o,
  output logic [IDX_W-1:0] ram_raddr_o,
  input  chan_rec_t        ram_rdata_i
);

  state_e           state_q, state_d;
  in_item_t         item_q, item_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] used_q, used_d;

  logic                  accept;
  logic                  ch_ok;
  logic                  table_full;
  logic                  more;
  logic [COUNT_BITS-1:0] rel_cnt;
  logic [COUNT_BITS-1:0] init_cnt;

  assign accept     = in_valid_i && in_ready_o;
  assign ch_ok      = 32'(item_q.channel) < 32'(used_q);
  assign table_full = 32'(used_q) >= MAX_CHANNELS;
  assign more       = (CNT_W'(idx_q) + CNT_W'(1)) < used_q;
  assign rel_cnt    = (item_q.reload_value == 16'd0) ? COUNT_BITS'(DEFAULT_RELOAD)
                                                     : COUNT_BITS'(item_q.reload_value);
  assign init_cnt   = (item_q.initial_value == 16'd0) ? rel_cnt
                                                      : COUNT_BITS'(item_q.initial_value);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    idx_d       = idx_q;
    used_d      = used_q;
    in_ready_o  = 1'b0;
    push_o      = 1'b0;
    res_o       = '{kind: KIND_ACK, slot: '0, owner: '0, online: 1'b0, last: 1'b1};
    ram_re_o    = 1'b0;
    ram_raddr_o = IDX_W'(in_data_i.channel);
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q;
    ram_wdata_o = ram_rdata_i;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          item_d = in_data_i;
          unique case (in_data_i.mode)
            MODE_REGISTER: state_d = ST_REG;
            MODE_KICK: begin
              ram_re_o = 1'b1;
              state_d  = ST_KICK;
            end
            MODE_QUERY: begin
              ram_re_o = 1'b1;
              state_d  = ST_QUERY;
            end
            MODE_TICK: begin
              idx_d = '0;
              if (used_q == '0) begin
                state_d = ST_TICK_DONE;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = '0;
                state_d     = ST_TICK;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_REG: begin
        if (out_free_i) begin
          push_o = 1'b1;
          if (table_full) begin
            res_o.kind = KIND_ERROR;
          end else begin
            ram_we_o    = 1'b1;
            ram_waddr_o = IDX_W'(used_q);
            ram_wdata_o = '{reload: rel_cnt, countdown: init_cnt, online: 1'b1,
                            owner: item_q.owner_tag, handler: item_q.has_handler};
            res_o.slot  = 4'(used_q);
            used_d      = used_q + CNT_W'(1);
          end
          state_d = ST_IDLE;
        end
      end

      ST_KICK: begin
        res_o.slot = item_q.channel;
        if (out_free_i) begin
          push_o = 1'b1;
          if (ch_ok) begin
            ram_we_o              = 1'b1;
            ram_waddr_o           = IDX_W'(item_q.channel);
            ram_wdata_o.countdown = ram_rdata_i.reload;
            ram_wdata_o.online    = 1'b1;
          end else begin
            res_o.kind = KIND_ERROR;
          end
          state_d = ST_IDLE;
        end
      end

      ST_QUERY: begin
        res_o.kind   = KIND_STATUS;
        res_o.slot   = item_q.channel;
        res_o.online = ch_ok && ram_rdata_i.online;
        if (out_free_i) begin
          push_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_TICK: begin
        res_o.kind  = KIND_OFFLINE;
        res_o.slot  = 4'(idx_q);
        res_o.owner = ram_rdata_i.owner;
        res_o.last  = 1'b0;
        // stall on the offline event until the output can take it
        if (out_free_i || ram_rdata_i.countdown != '0 || !ram_rdata_i.online ||
            !ram_rdata_i.handler) begin
          if (ram_rdata_i.countdown != '0) begin
            ram_we_o              = 1'b1;
            ram_wdata_o.countdown = ram_rdata_i.countdown - COUNT_BITS'(1);
          end else if (ram_rdata_i.online) begin
            ram_we_o           = 1'b1;
            ram_wdata_o.online = 1'b0;
            push_o             = ram_rdata_i.handler;
          end
          if (more) begin
            ram_re_o    = 1'b1;
            ram_raddr_o = idx_q + IDX_W'(1);
            idx_d       = idx_q + IDX_W'(1);
          end else begin
            state_d = ST_TICK_DONE;
          end
        end
      end

      ST_TICK_DONE: begin
        res_o.kind = KIND_DONE;
        if (out_free_i) begin
          push_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= MAX_CHANNELS)
    else $error("fill count beyond table size");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> out_free_i)
    else $error("result pushed into a full output register");

  a_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we_o && ram_re_o) |-> (ram_waddr_o != ram_raddr_o))
    else $error("read and write of the same entry in one cycle");

  a_tick_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK) |-> (CNT_W'(idx_q) < used_q))
    else $error("tick walks past the registered channels");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !ram_we_o)
    else $error("memory written while idle");

endmodule

// ===== hdl/multi_channel_liveness_watchdog.sv =====
// ----------------------------------------------------------------------------
// multi_channel_liveness_watchdog
// bank of liveness watchdog channels with a record memory and output register
// ----------------------------------------------------------------------------
// One command is handled at a time. Register, kick and query move to a state
// of their own and push the result from it into the output register, waiting
// while the output stalls; register writes the slot record, kick and query
// read it through the registered memory read port first. A tick visits the
// registered channels, up to MAX_CHANNELS, one per cycle through that read
// port, unless an offline event waits on a stalled output; the done marker
// that ends it may also wait on a stalled output. Channel records are not
// cleared at reset: only slots below the fill count are ever used. The next
// command is accepted while the last result still sits in the output register.
module multi_channel_liveness_watchdog import mclw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic             out_valid_q;
  out_item_t        out_data_q;
  logic             out_free;
  logic             push;
  out_item_t        res;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  chan_rec_t        ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  chan_rec_t        ram_rdata;

  assign out_free = !out_valid_q || out_ready_i;

  mclw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_free_i  (out_free),
    .push_o      (push),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  mclw_ram #(
    .WIDTH ($bits(chan_rec_t)),
    .DEPTH (MAX_CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && push) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
